// File: hw/rtl/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg
// types, constants and helper functions for the symmetric tensor index packer
// ----------------------------------------------------------------------------
package sti_pkg;

    localparam int NUM_IDX             = 8;
    localparam int IDX_W               = 2;
    localparam int SLOT_W              = 13;
    localparam int ACC_W               = 13;
    localparam int OFF_W               = 3;
    localparam int VAL_W               = 4;
    localparam int POS_W               = 3;
    localparam int DEFAULT_MAX_VALENCE = 8;

    // register byte addresses
    localparam logic [3:0] ADDR_VALENCE   = 4'h0;
    localparam logic [3:0] ADDR_SYM_FIRST = 4'h4;
    localparam logic [3:0] ADDR_SYM_SECOND = 4'h8;

    localparam logic [VAL_W-1:0] RESET_VALENCE    = 4'd2;
    localparam logic [POS_W-1:0] RESET_SYM_FIRST  = 3'd0;
    localparam logic [POS_W-1:0] RESET_SYM_SECOND = 3'd1;

    typedef enum logic
    {
        ACT_PACK   = 1'b0,
        ACT_UNPACK = 1'b1
    } sti_action_t;

    typedef enum logic [1:0]
    {
        ERR_NONE   = 2'd0,
        ERR_INDEX  = 2'd1,
        ERR_SLOT   = 2'd2,
        ERR_CONFIG = 2'd3
    } sti_err_t;

    // decoded configuration, symmetric pair already in ascending order
    typedef struct packed
    {
        logic [VAL_W-1:0] valence;
        logic [POS_W-1:0] sym_lo;
        logic [POS_W-1:0] sym_hi;
        logic             bad;
    } sti_cfg_t;

    // item travelling down the chain
    typedef struct packed
    {
        sti_action_t                      action;
        sti_err_t                         err;
        logic [NUM_IDX-1:0][IDX_W-1:0]    idx;
        logic [ACC_W-1:0]                 acc;
        logic [OFF_W-1:0]                 off;
    } sti_item_t;

    // floor(x / 3) by reciprocal multiply, exact for every 12-bit x
    function automatic logic [10:0] div3(input logic [11:0] x);
        logic [23:0] prod;
        prod = {12'd0, x} * 24'd2731;
        return prod[23:13];
    endfunction

    // offset of the unordered pair within the six stored combinations
    function automatic logic [OFF_W-1:0] pair_offset(input logic [IDX_W-1:0] a,
                                                     input logic [IDX_W-1:0] b);
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [OFF_W-1:0] res;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (lo == 2'd1)
            res = {1'b0, hi} - 3'd1;
        else if (lo == 2'd2)
            res = {1'b0, hi} + 3'd1;
        else
            res = 3'd5;
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] pair_hi(input logic [OFF_W-1:0] r);
        logic [IDX_W-1:0] res;
        unique case (r)
            3'd0, 3'd1, 3'd2: res = 2'd1;
            3'd3, 3'd4:       res = 2'd2;
            default:          res = 2'd3;
        endcase
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] pair_lo(input logic [OFF_W-1:0] r);
        logic [IDX_W-1:0] res;
        unique case (r)
            3'd0:       res = 2'd1;
            3'd1, 3'd3: res = 2'd2;
            default:    res = 2'd3;
        endcase
        return res;
    endfunction

    // number of stored components, 6 * 3^(v-2)
    function automatic logic [SLOT_W-1:0] num_comp(input logic [VAL_W-1:0] v);
        logic [SLOT_W-1:0] res;
        unique case (v)
            4'd2:    res = 13'd6;
            4'd3:    res = 13'd18;
            4'd4:    res = 13'd54;
            4'd5:    res = 13'd162;
            4'd6:    res = 13'd486;
            4'd7:    res = 13'd1458;
            4'd8:    res = 13'd4374;
            default: res = 13'd0;
        endcase
        return res;
    endfunction

endpackage

// File: hw/rtl/sti_front.sv
// ----------------------------------------------------------------------------
// sti_front
// entry stage: configuration check, pair offset and split of the slot by six
// ----------------------------------------------------------------------------
module sti_front
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  sti_pkg::sti_cfg_t                            cfg,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  sti_pkg::sti_action_t                         in_action,
    input  logic [sti_pkg::NUM_IDX-1:0][sti_pkg::IDX_W-1:0] in_idx,
    input  logic [sti_pkg::SLOT_W-1:0]                   in_slot,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output sti_pkg::sti_item_t                           out_item
);
    import sti_pkg::*;

    logic              valid_reg;
    sti_item_t         item_reg;
    sti_item_t         item_next;
    logic [10:0]       quot;
    logic [SLOT_W-1:0] quot_x6;
    logic [SLOT_W-1:0] rem6;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        quot    = div3(in_slot[SLOT_W-1:1]);
        quot_x6 = {quot, 2'b00} + {1'b0, quot, 1'b0};
        rem6    = in_slot - quot_x6;

        item_next        = '0;
        item_next.action = in_action;
        item_next.err    = ERR_NONE;
        if (cfg.bad)
        begin
            item_next.err = ERR_CONFIG;
        end
        else if (in_action == ACT_PACK)
        begin
            item_next.idx = in_idx;
            item_next.off = pair_offset(in_idx[cfg.sym_lo], in_idx[cfg.sym_hi]);
        end
        else
        begin
            if (in_slot >= num_comp(cfg.valence))
                item_next.err = ERR_SLOT;
            item_next.acc                = {2'b00, quot};
            item_next.idx[cfg.sym_lo]    = pair_hi(rem6[OFF_W-1:0]);
            item_next.idx[cfg.sym_hi]    = pair_lo(rem6[OFF_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

endmodule

// File: hw/rtl/sti_cell.sv
// ----------------------------------------------------------------------------
// sti_cell
// one chain cell: one base-3 digit, packed on the way in or peeled off on the
// way out
// ----------------------------------------------------------------------------
module sti_cell
#(
    parameter int POS_FWD = 0,
    parameter int POS_REV = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  sti_pkg::sti_cfg_t  cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  sti_pkg::sti_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output sti_pkg::sti_item_t out_item
);
    import sti_pkg::*;

    localparam logic [VAL_W-1:0] FWD_V = VAL_W'(POS_FWD);
    localparam logic [POS_W-1:0] FWD_P = POS_W'(POS_FWD);
    localparam logic [VAL_W-1:0] REV_V = VAL_W'(POS_REV);
    localparam logic [POS_W-1:0] REV_P = POS_W'(POS_REV);

    logic             valid_reg;
    sti_item_t        item_reg;
    sti_item_t        item_next;
    logic [10:0]      quot;
    logic [11:0]      quot_x3;
    logic [11:0]      rem3;
    logic [ACC_W-1:0] acc_x3;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        quot      = div3(in_item.acc[11:0]);
        quot_x3   = {1'b0, quot} + {quot, 1'b0};
        rem3      = in_item.acc[11:0] - quot_x3;
        acc_x3    = {in_item.acc[ACC_W-2:0], 1'b0} + in_item.acc;
        item_next = in_item;
        if (in_item.err == ERR_NONE)
        begin
            if (in_item.action == ACT_PACK)
            begin
                if (FWD_V < cfg.valence)
                begin
                    if (in_item.idx[POS_FWD] == 2'd0)
                        item_next.err = ERR_INDEX;
                    else if (FWD_P != cfg.sym_lo && FWD_P != cfg.sym_hi)
                        item_next.acc = acc_x3 + ACC_W'(in_item.idx[POS_FWD] - 2'd1);
                end
            end
            else
            begin
                if (REV_V < cfg.valence && REV_P != cfg.sym_lo && REV_P != cfg.sym_hi)
                begin
                    item_next.idx[POS_REV] = rem3[IDX_W-1:0] + 2'd1;
                    item_next.acc          = {2'b00, quot};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

endmodule

// File: hw/rtl/sti_back.sv
// ----------------------------------------------------------------------------
// sti_back
// exit stage: final scaling by six, clearing of unused fields, output register
// ----------------------------------------------------------------------------
module sti_back
(
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    output logic                                            in_ready,
    input  sti_pkg::sti_item_t                              in_item,
    output logic                                            out_valid,
    input  logic                                            out_ready,
    output logic [sti_pkg::SLOT_W-1:0]                      out_slot,
    output logic [sti_pkg::NUM_IDX-1:0][sti_pkg::IDX_W-1:0] out_idx,
    output sti_pkg::sti_err_t                               out_err
);
    import sti_pkg::*;

    logic                          valid_reg;
    logic [SLOT_W-1:0]             slot_reg;
    logic [SLOT_W-1:0]             slot_next;
    logic [NUM_IDX-1:0][IDX_W-1:0] idx_reg;
    logic [NUM_IDX-1:0][IDX_W-1:0] idx_next;
    sti_err_t                      err_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_slot  = slot_reg;
    assign out_idx   = idx_reg;
    assign out_err   = err_reg;

    always_comb
    begin
        slot_next = '0;
        idx_next  = '0;
        if (in_item.err == ERR_NONE)
        begin
            if (in_item.action == ACT_PACK)
                slot_next = {in_item.acc[10:0], 2'b00} + {in_item.acc[11:0], 1'b0}
                          + SLOT_W'(in_item.off);
            else
                idx_next = in_item.idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            slot_reg <= slot_next;
            idx_reg  <= idx_next;
            err_reg  <= in_item.err;
        end
    end

endmodule

// File: hw/rtl/symmetric_tensor_index_packer.sv
// ----------------------------------------------------------------------------
// symmetric_tensor_index_packer
// packs an index tuple into its slot of symmetric storage, or unpacks a slot
// stages: one entry stage, one cell per index position that the valence can
// reach, one output register
// throughput: one transaction per cycle, set by the cell chain, unless m_tready stalls
// reset: asynchronous active low; clears stage valids and restores
// valence 2 with the symmetric pair at positions 0 and 1
// ----------------------------------------------------------------------------
module symmetric_tensor_index_packer
#(
    parameter int MAX_VALENCE = sti_pkg::DEFAULT_MAX_VALENCE
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // index_0 .. index_7, slot_in
    input  logic        s_tuser,   // action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // slot_out, out_index_0 .. out_index_7, error_code
);
    import sti_pkg::*;

    // one cell per index position that the valence can reach
    localparam int NUM_CELLS = (MAX_VALENCE < NUM_IDX) ? MAX_VALENCE : NUM_IDX;

    // configuration registers
    logic [VAL_W-1:0] valence_reg;
    logic [POS_W-1:0] sym_first_reg;
    logic [POS_W-1:0] sym_second_reg;
    logic             cfg_write;
    sti_cfg_t         cfg;

    // chain links, link k feeds cell k
    logic      link_valid [NUM_CELLS+1];
    logic      link_ready [NUM_CELLS+1];
    sti_item_t link_item  [NUM_CELLS+1];

    logic [SLOT_W-1:0]             res_slot;
    logic [NUM_IDX-1:0][IDX_W-1:0] res_idx;
    sti_err_t                      res_err;

    // register writes complete in the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valence_reg    <= RESET_VALENCE;
            sym_first_reg  <= RESET_SYM_FIRST;
            sym_second_reg <= RESET_SYM_SECOND;
        end
        else if (cfg_write)
        begin
            unique case (paddr)
                ADDR_VALENCE:    valence_reg    <= pwdata[VAL_W-1:0];
                ADDR_SYM_FIRST:  sym_first_reg  <= pwdata[POS_W-1:0];
                ADDR_SYM_SECOND: sym_second_reg <= pwdata[POS_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_VALENCE:    prdata = {28'd0, valence_reg};
            ADDR_SYM_FIRST:  prdata = {29'd0, sym_first_reg};
            ADDR_SYM_SECOND: prdata = {29'd0, sym_second_reg};
            default:         prdata = '0;
        endcase
    end

    // ascending pair and legality check, read directly by entry stage and cells;
    // user must change it only while the block is idle, not enforced by the block
    always_comb
    begin
        cfg.valence = valence_reg;
        cfg.sym_lo  = (sym_first_reg > sym_second_reg) ? sym_second_reg : sym_first_reg;
        cfg.sym_hi  = (sym_first_reg > sym_second_reg) ? sym_first_reg : sym_second_reg;
        cfg.bad     = (valence_reg < 4'd2)
                   || (valence_reg > VAL_W'(MAX_VALENCE))
                   || (valence_reg > VAL_W'(NUM_IDX))
                   || (sym_first_reg == sym_second_reg)
                   || ({1'b0, cfg.sym_hi} >= valence_reg);
    end

    // entry stage
    sti_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (sti_action_t'(s_tuser)),
        .in_idx    (s_tdata[NUM_IDX*IDX_W-1:0]),
        .in_slot   (s_tdata[NUM_IDX*IDX_W+SLOT_W-1:NUM_IDX*IDX_W]),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_item  (link_item[0])
    );

    // packing walks positions upwards, unpacking walks them downwards, so
    // cell k owns position k going in and position NUM_CELLS-1-k coming out
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        sti_cell
        #(
            .POS_FWD (k),
            .POS_REV (NUM_CELLS - 1 - k)
        )
        u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (cfg),
            .in_valid  (link_valid[k]),
            .in_ready  (link_ready[k]),
            .in_item   (link_item[k]),
            .out_valid (link_valid[k+1]),
            .out_ready (link_ready[k+1]),
            .out_item  (link_item[k+1])
        );
    end

    // output register, parts the chain from the result stream
    sti_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (link_valid[NUM_CELLS]),
        .in_ready  (link_ready[NUM_CELLS]),
        .in_item   (link_item[NUM_CELLS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_slot  (res_slot),
        .out_idx   (res_idx),
        .out_err   (res_err)
    );

    assign m_tdata = {1'b0, res_err, res_idx, res_slot};

endmodule
